/* rtl/core/gbce_pkg.sv */
package gbce_pkg;

  // parameter defaults
  localparam int MAX_CELLS_DEF = 16;
  localparam int MAX_SPAN_DEF  = 4;
  localparam int FRAC_BITS_DEF = 16;

  // fixed field widths
  localparam int COORD_W = 32;
  localparam int IDX_W   = 12;
  localparam int CELLS_W = 5;
  localparam int AXES_W  = 2;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;

  // register map, one word each
  typedef enum logic [2:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_SCALE_X,
    REG_SCALE_Y,
    REG_SCALE_Z,
    REG_CELLS,
    REG_NUM_AXES
  } reg_idx_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DRAIN,
    ST_PREP1,
    ST_PREP2,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic prep1;
    logic prep2;
    logic step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_corner;
    logic walk_last;
    logic out_free;
  } status_t;

  // configuration registers
  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic [COORD_W-1:0]        scale_x;
    logic [COORD_W-1:0]        scale_y;
    logic [COORD_W-1:0]        scale_z;
    logic [CELLS_W-1:0]        cells;
    logic [AXES_W-1:0]         axes;
  } cfg_t;

endpackage

/* rtl/core/gbce_regs.sv */
module gbce_regs import gbce_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x <= '0;
      cfg.origin_y <= '0;
      cfg.origin_z <= '0;
      cfg.scale_x  <= COORD_W'(1) << FRAC_BITS;
      cfg.scale_y  <= COORD_W'(1) << FRAC_BITS;
      cfg.scale_z  <= COORD_W'(1) << FRAC_BITS;
      cfg.cells    <= CELLS_W'(1);
      cfg.axes     <= AXES_W'(3);
    end else if (wr) begin
      case (idx)
        REG_ORIGIN_X: cfg.origin_x <= pwdata;
        REG_ORIGIN_Y: cfg.origin_y <= pwdata;
        REG_ORIGIN_Z: cfg.origin_z <= pwdata;
        REG_SCALE_X:  cfg.scale_x  <= pwdata;
        REG_SCALE_Y:  cfg.scale_y  <= pwdata;
        REG_SCALE_Z:  cfg.scale_z  <= pwdata;
        REG_CELLS:    cfg.cells    <= pwdata[CELLS_W-1:0];
        REG_NUM_AXES: cfg.axes     <= pwdata[AXES_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (idx)
      REG_ORIGIN_X: prdata = cfg.origin_x;
      REG_ORIGIN_Y: prdata = cfg.origin_y;
      REG_ORIGIN_Z: prdata = cfg.origin_z;
      REG_SCALE_X:  prdata = cfg.scale_x;
      REG_SCALE_Y:  prdata = cfg.scale_y;
      REG_SCALE_Z:  prdata = cfg.scale_z;
      REG_CELLS:    prdata = DATA_W'(cfg.cells);
      REG_NUM_AXES: prdata = DATA_W'(cfg.axes);
      default:      prdata = '0;
    endcase
  end

endmodule

/* rtl/core/gbce_ctrl.sv */
module gbce_ctrl import gbce_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output cmd_t    cmd,
  input  status_t status
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_CALC;
      ST_CALC:  if (status.last_corner) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_PREP1;
      ST_PREP1: state_next = ST_PREP2;
      ST_PREP2: state_next = ST_EMIT;
      ST_EMIT:  if (status.out_free && status.walk_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_CALC:  cmd.issue = 1'b1;
      ST_DRAIN: ;
      ST_PREP1: cmd.prep1 = 1'b1;
      ST_PREP2: cmd.prep2 = 1'b1;
      ST_EMIT:  cmd.step  = status.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/core/gbce_dp.sv */
module gbce_dp import gbce_pkg::*; #(
  parameter int MAX_CELLS_PER_AXIS = MAX_CELLS_DEF,
  parameter int MAX_SPAN           = MAX_SPAN_DEF,
  parameter int FRAC_BITS          = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  cmd_t                      cmd,
  output status_t                   status,
  input  logic signed [COORD_W-1:0] min_x,
  input  logic signed [COORD_W-1:0] min_y,
  input  logic signed [COORD_W-1:0] min_z,
  input  logic signed [COORD_W-1:0] max_x,
  input  logic signed [COORD_W-1:0] max_y,
  input  logic signed [COORD_W-1:0] max_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [IDX_W-1:0]          cell_index,
  output logic                      is_last,
  output logic                      no_cell,
  output logic                      span_capped
);

  localparam int CW     = $clog2(MAX_CELLS_PER_AXIS + 1);
  localparam int SPAN_W = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
  localparam int PW     = 2 * COORD_W;
  localparam int QW     = PW - 2 * FRAC_BITS;

  // effective grid size and axis count
  logic [CW-1:0]     cells_eff;
  logic [AXES_W-1:0] axes_eff;

  always_comb begin
    if (cfg.cells == '0) begin
      cells_eff = CW'(1);
    end else if (32'(cfg.cells) > 32'(MAX_CELLS_PER_AXIS)) begin
      cells_eff = CW'(MAX_CELLS_PER_AXIS);
    end else begin
      cells_eff = CW'(cfg.cells);
    end
  end

  assign axes_eff = (cfg.axes == '0) ? AXES_W'(1) : cfg.axes;

  // captured box corners
  logic signed [COORD_W-1:0] lo_coord [3];
  logic signed [COORD_W-1:0] hi_coord [3];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_coord[0] <= min_x;
      lo_coord[1] <= min_y;
      lo_coord[2] <= min_z;
      hi_coord[0] <= max_x;
      hi_coord[1] <= max_y;
      hi_coord[2] <= max_z;
    end
  end

  // corner counter: min and max of each axis in turn
  logic [2:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.issue) begin
      cnt <= cnt + 3'd1;
    end
  end

  assign status.last_corner = (cnt == (3'({axes_eff, 1'b0}) - 3'd1));

  // multiply stage: |coord - origin| * scale
  logic [1:0]                axis_sel;
  logic signed [COORD_W-1:0] coord;
  logic signed [COORD_W-1:0] origin;
  logic [COORD_W-1:0]        scale;
  logic signed [COORD_W:0]   diff;
  logic [COORD_W:0]          diff_neg;
  logic [COORD_W-1:0]        mag;

  assign axis_sel = cnt[2:1];

  always_comb begin
    case (axis_sel)
      2'd0: begin
        origin = cfg.origin_x;
        scale  = cfg.scale_x;
        coord  = cnt[0] ? hi_coord[0] : lo_coord[0];
      end
      2'd1: begin
        origin = cfg.origin_y;
        scale  = cfg.scale_y;
        coord  = cnt[0] ? hi_coord[1] : lo_coord[1];
      end
      default: begin
        origin = cfg.origin_z;
        scale  = cfg.scale_z;
        coord  = cnt[0] ? hi_coord[2] : lo_coord[2];
      end
    endcase
  end

  assign diff     = {coord[COORD_W-1], coord} - {origin[COORD_W-1], origin};
  assign diff_neg = -diff;
  assign mag      = diff[COORD_W] ? diff_neg[COORD_W-1:0] : diff[COORD_W-1:0];

  logic [PW-1:0] prod;
  logic          neg;
  logic [2:0]    tag;
  logic          pvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
    end else begin
      pvalid <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      prod <= PW'(mag) * PW'(scale);
      neg  <= diff[COORD_W];
      tag  <= cnt;
    end
  end

  // clip stage: floor, then clamp to the grid
  logic [QW-1:0] q;
  logic          prod_zero;
  logic          beyond;
  logic [1:0]    tag_axis;

  assign q         = prod[PW-1:2*FRAC_BITS];
  assign prod_zero = (prod == '0);
  assign beyond    = (q >= QW'(cells_eff));
  assign tag_axis  = tag[2:1];

  logic [CW-1:0] lo_cell [3];
  logic [CW-1:0] hi_cell [3];
  logic          hi_neg  [3];

  always_ff @(posedge clk) begin
    if (pvalid) begin
      if (!tag[0]) begin
        lo_cell[tag_axis] <= neg ? '0 : (beyond ? cells_eff : CW'(q));
      end else begin
        hi_neg[tag_axis]  <= neg && !prod_zero;
        hi_cell[tag_axis] <= neg ? '0 : (beyond ? cells_eff - CW'(1) : CW'(q));
      end
    end
  end

  // per-axis range check and span cap
  logic [2:0]        axis_used;
  logic [2:0]        axis_empty;
  logic [2:0]        axis_capped;
  logic [CW-1:0]     span   [3];
  logic [SPAN_W-1:0] last_o [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      axis_used[a]   = (32'(axes_eff) > a);
      axis_empty[a]  = hi_neg[a] || (lo_cell[a] > hi_cell[a]);
      span[a]        = hi_cell[a] - lo_cell[a];
      axis_capped[a] = !axis_empty[a] && (32'(span[a]) >= 32'(MAX_SPAN));
      if (!axis_used[a]) begin
        last_o[a] = '0;
      end else if (axis_capped[a]) begin
        last_o[a] = SPAN_W'(MAX_SPAN - 1);
      end else begin
        last_o[a] = SPAN_W'(span[a]);
      end
    end
  end

  // starting index by Horner steps, and strides
  logic [IDX_W-1:0] cells_w;
  logic [IDX_W-1:0] t1;
  logic [IDX_W-1:0] t2;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] stride0;
  logic [IDX_W-1:0] stride1;

  assign cells_w = IDX_W'(cells_eff);
  assign t2 = (axes_eff == AXES_W'(3)) ? t1 * cells_w + IDX_W'(lo_cell[2]) : t1;

  logic              empty;
  logic              capped;
  logic [SPAN_W-1:0] off     [3];
  logic [SPAN_W-1:0] last_r  [3];
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  row;
  logic [IDX_W-1:0]  plane;
  logic              walk_end;

  assign walk_end = (off[0] == last_r[0]) && (off[1] == last_r[1]) &&
                    (off[2] == last_r[2]);
  assign status.walk_last = walk_end || empty;

  always_ff @(posedge clk) begin
    if (cmd.prep1) begin
      empty  <= |(axis_empty & axis_used);
      capped <= |(axis_capped & axis_used);
      for (int a = 0; a < 3; a++) begin
        last_r[a] <= last_o[a];
        off[a]    <= '0;
      end
      t1   <= (axes_eff == AXES_W'(1)) ? IDX_W'(lo_cell[0])
            : IDX_W'(lo_cell[0]) * cells_w + IDX_W'(lo_cell[1]);
      head <= cells_w * cells_w;
      if (axes_eff == AXES_W'(3)) begin
        stride1 <= cells_w;
      end else begin
        stride1 <= IDX_W'(1);
      end
    end
    if (cmd.prep2) begin
      idx   <= t2;
      row   <= t2;
      plane <= t2;
      case (axes_eff)
        AXES_W'(3): stride0 <= head;
        AXES_W'(2): stride0 <= cells_w;
        default:    stride0 <= IDX_W'(1);
      endcase
    end
    // walk the covered cells, last axis innermost
    if (cmd.step && !walk_end) begin
      if (off[2] != last_r[2]) begin
        off[2] <= off[2] + SPAN_W'(1);
        idx    <= idx + IDX_W'(1);
      end else if (off[1] != last_r[1]) begin
        off[2] <= '0;
        off[1] <= off[1] + SPAN_W'(1);
        row    <= row + stride1;
        idx    <= row + stride1;
      end else begin
        off[2] <= '0;
        off[1] <= '0;
        off[0] <= off[0] + SPAN_W'(1);
        plane  <= plane + stride0;
        row    <= plane + stride0;
        idx    <= plane + stride0;
      end
    end
  end

  // result register
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      cell_index  <= empty ? '0 : idx;
      is_last     <= walk_end || empty;
      no_cell     <= empty;
      span_capped <= capped && !empty;
    end
  end

endmodule

/* rtl/core/grid_box_cell_enumerator_top.sv */
// Box to grid cell enumerator. Each request is a box (min and max corner per axis, signed
// fixed point); the block returns one result per covered grid cell (at most MAX_SPAN per
// axis, with span_capped set when cut) in row-major order with the last axis innermost,
// is_last on the final one, or a single no_cell result for an empty box. One request is
// handled at a time: after acceptance, a single shared 32x32 multiplier quantizes the
// 2 * num_axes corners one per cycle, then the DRAIN, PREP1 and PREP2 states clip the
// ranges and form the first index; one result then leaves per cycle while out_stall is
// low. The next request is taken once the last result of the previous box is registered.
module grid_box_cell_enumerator_top import gbce_pkg::*; #(
  parameter int MAX_CELLS_PER_AXIS = MAX_CELLS_DEF,
  parameter int MAX_SPAN           = MAX_SPAN_DEF,
  parameter int FRAC_BITS          = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] min_x,
  input  logic signed [COORD_W-1:0] min_y,
  input  logic signed [COORD_W-1:0] min_z,
  input  logic signed [COORD_W-1:0] max_x,
  input  logic signed [COORD_W-1:0] max_y,
  input  logic signed [COORD_W-1:0] max_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [IDX_W-1:0]          cell_index,
  output logic                      is_last,
  output logic                      no_cell,
  output logic                      span_capped
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // configuration registers
  gbce_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  gbce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  // quantize, clip and walk
  gbce_dp #(
    .MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS),
    .MAX_SPAN           (MAX_SPAN),
    .FRAC_BITS          (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .min_x       (min_x),
    .min_y       (min_y),
    .min_z       (min_z),
    .max_x       (max_x),
    .max_y       (max_y),
    .max_z       (max_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cell_index  (cell_index),
    .is_last     (is_last),
    .no_cell     (no_cell),
    .span_capped (span_capped)
  );

endmodule
